### rtl/alf_pkg.sv
// Shared types, constants and helpers of the lagged Fibonacci generator.
package alf_pkg;

	// Table geometry: long and short lag, index width.
	localparam int LagLong  = 607;
	localparam int LagShort = 273;
	localparam int IdxW     = $clog2(LagLong);
	localparam int WordW    = 31;

	// Seeding sequence: warm-up steps that are thrown away, then one step per entry.
	localparam int WarmupSteps = 20;
	localparam int TotalSteps  = WarmupSteps + LagLong;
	localparam int StepW       = $clog2(TotalSteps);

	// Minimal standard generator constants, modulus 2^31-1.
	localparam logic [WordW-1:0] PmMod    = 31'h7fff_ffff;
	localparam int               PmMulW   = 16;
	localparam logic [PmMulW-1:0] PmMul   = 16'd48271;
	localparam logic [WordW-1:0] ZeroSeed = 31'd89482311;
	localparam int               ProdW    = WordW + PmMulW;

	// Feed index right after a reseed; the tap index starts at zero.
	localparam logic [IdxW-1:0] FeedInit = IdxW'(LagLong - LagShort);

	// Operation codes of an input word.
	localparam logic OpDraw   = 1'b0;
	localparam logic OpReseed = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PM_ISSUE,
		ST_PM_WAIT,
		ST_RD_FEED,
		ST_RD_TAP,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [WordW-1:0] x;
	} pm_req_t;

	typedef struct packed {
		logic             done;
		logic [WordW-1:0] value;
	} pm_rsp_t;

	// Move an index down one place, wrapping to the top of the table.
	function automatic logic [IdxW-1:0] step_down(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] res;
		if (idx == '0 || idx >= IdxW'(LagLong)) begin
			res = IdxW'(LagLong - 1);
		end else begin
			res = idx - 1'b1;
		end
		return res;
	endfunction

endpackage

### rtl/alf_pm_unit.sv
// Two-stage multiply and fold unit for one step x = 48271 * x mod (2^31 - 1).
module alf_pm_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  alf_pkg::pm_req_t req,
	output alf_pkg::pm_rsp_t rsp
);

	logic                       vld_s1;
	logic [alf_pkg::ProdW-1:0]  prod_s1;
	logic                       done_q;
	logic [alf_pkg::WordW-1:0]  res_q;
	logic [alf_pkg::WordW:0]    fold_sum;
	logic [alf_pkg::WordW-1:0]  fold_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			done_q <= vld_s1;
		end
	end

	// Since 2^31 is 1 modulo the modulus, the high part simply adds to the low part.
	always_comb begin
		fold_sum = {1'b0, prod_s1[alf_pkg::WordW-1:0]}
			+ (alf_pkg::WordW + 1)'(prod_s1[alf_pkg::ProdW-1:alf_pkg::WordW]);
		if (fold_sum >= {1'b0, alf_pkg::PmMod}) begin
			fold_res = alf_pkg::WordW'(fold_sum - {1'b0, alf_pkg::PmMod});
		end else begin
			fold_res = fold_sum[alf_pkg::WordW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= alf_pkg::ProdW'(req.x) * alf_pkg::ProdW'(alf_pkg::PmMul);
		res_q   <= fold_res;
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

### rtl/additive_lagged_fibonacci_rng.sv
// Top level of the additive lagged Fibonacci generator, lags 607 and 273.
//
// Usage: the input channel (in_valid, in_ready, operation, seed) takes one word
// at a time. A draw word (operation 0) returns one 31-bit number on the output
// channel (out_valid, out_ready, value); a reseed word (operation 1) reduces
// the signed seed modulo 2^31-1 and refills the 607-entry lag table from the
// minimal standard generator, and returns nothing.
// A draw on a seeded block goes through the states read feed, read tap, sum
// and output before the block is ready again, so a new draw is taken only
// after the last one is through. The single read port of the table memory sets
// this: the feed entry and then the tap entry are read, then the sum is written back.
// A reseed keeps in_ready low through one issue step plus 627 steps of the
// shared two-stage multiply and fold unit. A draw before any reseed first
// seeds with 1 and then runs like any other draw.
// Reset clears the indices and the seeded flag and empties the output register;
// the table keeps whatever it held and is rewritten on the first seeding.
// When the receiver stalls, a finished result waits in the output register
// while the next word is taken; the draw after it holds in its last step
// until the output register is free again.
module additive_lagged_fibonacci_rng (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic signed [31:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] value
);

	localparam int IdxW  = alf_pkg::IdxW;
	localparam int WordW = alf_pkg::WordW;
	localparam int StepW = alf_pkg::StepW;

	alf_pkg::state_t state_q, state_d;

	logic [IdxW-1:0]  tap_q;
	logic [IdxW-1:0]  feed_q;
	logic             seeded_q;
	logic             pending_q;
	logic [StepW-1:0] step_cnt_q;
	logic             out_valid_q;

	logic [WordW-1:0] x_q;
	logic [WordW-1:0] a_q;
	logic [WordW-1:0] sum_q;
	logic [WordW-1:0] value_q;
	logic [WordW-1:0] rd_data_q;

	// Lag table: one write port and one registered read port.
	logic [WordW-1:0] mem [alf_pkg::LagLong];

	alf_pkg::pm_req_t pm_req;
	alf_pkg::pm_rsp_t pm_rsp;

	logic             accept;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	logic [WordW-1:0] wr_data;
	logic [IdxW-1:0]  rd_addr;
	logic             load_out;
	logic             fill_done;
	logic [WordW-1:0] sum_comb;
	logic [IdxW-1:0]  fill_addr;
	logic [31:0]      seed_u;
	logic [31:0]      seed_mod;
	logic [WordW-1:0] seed_red;

	alf_pm_unit u_pm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pm_req),
		.rsp    (pm_rsp)
	);

	assign accept    = in_valid && in_ready;
	assign sum_comb  = a_q + rd_data_q;
	assign fill_addr = IdxW'(step_cnt_q - StepW'(alf_pkg::WarmupSteps));
	assign seed_u    = seed;

	// Seed reduction with a truncating remainder: a negative seed gets the
	// modulus added once, except the most negative value, whose remainder is
	// minus one. A result of zero is replaced by a fixed nonzero seed.
	always_comb begin
		if (seed_u[31]) begin
			if (seed_u == 32'h8000_0000) begin
				seed_mod = {1'b0, alf_pkg::PmMod} - 32'd1;
			end else begin
				seed_mod = seed_u + {1'b0, alf_pkg::PmMod};
			end
		end else if (seed_u == {1'b0, alf_pkg::PmMod}) begin
			seed_mod = '0;
		end else begin
			seed_mod = seed_u;
		end
		if (seed_mod == '0) begin
			seed_red = alf_pkg::ZeroSeed;
		end else begin
			seed_red = seed_mod[WordW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: seeding runs the shared unit back to back, each result feeding the
	// next step; a draw reads feed, then tap, writes the sum back and loads the output.
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		pm_req.start = 1'b0;
		pm_req.x     = pm_rsp.value;
		wr_en        = 1'b0;
		wr_addr      = feed_q;
		wr_data      = sum_comb;
		rd_addr      = feed_q;
		load_out     = 1'b0;
		fill_done    = 1'b0;
		unique case (state_q)
			alf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == alf_pkg::OpReseed || !seeded_q) begin
						state_d = alf_pkg::ST_PM_ISSUE;
					end else begin
						state_d = alf_pkg::ST_RD_FEED;
					end
				end
			end
			alf_pkg::ST_PM_ISSUE: begin
				pm_req.start = 1'b1;
				pm_req.x     = x_q;
				state_d      = alf_pkg::ST_PM_WAIT;
			end
			alf_pkg::ST_PM_WAIT: begin
				if (pm_rsp.done) begin
					if (step_cnt_q >= StepW'(alf_pkg::WarmupSteps)) begin
						wr_en   = 1'b1;
						wr_addr = fill_addr;
						wr_data = pm_rsp.value;
					end
					if (step_cnt_q == StepW'(alf_pkg::TotalSteps - 1)) begin
						fill_done = 1'b1;
						state_d   = pending_q ? alf_pkg::ST_RD_FEED : alf_pkg::ST_IDLE;
					end else begin
						pm_req.start = 1'b1;
					end
				end
			end
			alf_pkg::ST_RD_FEED: begin
				rd_addr = feed_q;
				state_d = alf_pkg::ST_RD_TAP;
			end
			alf_pkg::ST_RD_TAP: begin
				rd_addr = tap_q;
				state_d = alf_pkg::ST_SUM;
			end
			alf_pkg::ST_SUM: begin
				wr_en   = 1'b1;
				wr_addr = feed_q;
				wr_data = sum_comb;
				state_d = alf_pkg::ST_OUT;
			end
			alf_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = alf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = alf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q       <= '0;
			feed_q      <= '0;
			seeded_q    <= 1'b0;
			pending_q   <= 1'b0;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (operation == alf_pkg::OpReseed) begin
					pending_q  <= 1'b0;
					step_cnt_q <= '0;
				end else if (!seeded_q) begin
					pending_q  <= 1'b1;
					step_cnt_q <= '0;
				end else begin
					tap_q  <= alf_pkg::step_down(tap_q);
					feed_q <= alf_pkg::step_down(feed_q);
				end
			end
			if (state_q == alf_pkg::ST_PM_WAIT && pm_rsp.done) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end
			// A draw that waited for the seeding moves its indices here.
			if (fill_done) begin
				seeded_q <= 1'b1;
				if (pending_q) begin
					tap_q  <= alf_pkg::step_down('0);
					feed_q <= alf_pkg::step_down(alf_pkg::FeedInit);
				end else begin
					tap_q  <= '0;
					feed_q <= alf_pkg::FeedInit;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= (operation == alf_pkg::OpReseed) ? seed_red : WordW'(1);
		end
		if (state_q == alf_pkg::ST_RD_TAP) begin
			a_q <= rd_data_q;
		end
		if (state_q == alf_pkg::ST_SUM) begin
			sum_q <= sum_comb;
		end
		if (load_out) begin
			value_q <= sum_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Distance from tap to feed, around the ring.
	logic [IdxW:0] lag_dist;
	assign lag_dist = (tap_q >= feed_q)
		? ({1'b0, tap_q} - {1'b0, feed_q})
		: ({1'b0, tap_q} + (IdxW + 1)'(alf_pkg::LagLong) - {1'b0, feed_q});

	a_lag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> lag_dist == (IdxW + 1)'(alf_pkg::LagShort))
		else $error("tap and feed indices lost their lag");

	a_pm_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pm_rsp.done |-> state_q == alf_pkg::ST_PM_WAIT)
		else $error("multiply unit finished outside the seeding loop");

	a_draw_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == alf_pkg::ST_RD_FEED |-> seeded_q)
		else $error("table read before it was seeded");

	a_out_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == alf_pkg::ST_OUT)
		else $error("result appeared without a finished draw");

endmodule
